### rtl/core/dvru_pkg.sv
`default_nettype none
// ============================================================================
// dvru_pkg: shared types and constants
// Widths of the cost fields, configuration register codes and the states of
// the route update sequencer.
// ============================================================================
package dvru_pkg;

    localparam int NODES_DEF    = 4;
    localparam int INF_COST_DEF = 9999;
    localparam int COST_PORTS   = 4;
    localparam int ID_W         = 2;
    localparam int VEC_W        = 14;
    localparam int COST_W       = 15;
    localparam int SUM_W        = 16;
    localparam int LINK_W       = 16;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID    = 1'b0,
        CFG_LINK_COSTS = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_SRC,
        S_RD_OWN,
        S_RELAX,
        S_SEND
    } t_state;

endpackage
`default_nettype wire

### rtl/core/distance_vector_route_update.sv
`default_nettype none
// ============================================================================
// distance_vector_route_update: distance-vector route table update
// Keeps the distance table of one router node and relaxes its own vector
// with each neighbor vector that arrives.
//
// Input channel (i_valid/o_ready): one request carries a neighbor's whole
// distance vector. Requests are taken one at a time; o_ready is high only
// while the block is idle.
// Processing: accept, read the sender's row, read the own row (writing the
// new sender row), relax and write back, then offer the first update packet;
// the table's single read port makes the two row reads go one after another.
// Output channel (o_valid/i_ready): one update packet per neighbor with a
// finite link, at most 3, from a registered output; o_last_packet marks the
// final one. An ignored request frees the input after the sender's row read,
// a repeated row or a vector from this node after the own row read, and a
// request that sends nothing after the relax step. A stalled receiver holds
// the packet and the input stays closed until the last packet is taken.
// Reset and every configuration write reload the table at once: all rows
// infinite, the own row from the link cost register; no clearing pass.
// ============================================================================
module distance_vector_route_update #(
    parameter int NODES         = dvru_pkg::NODES_DEF,
    parameter int INFINITE_COST = dvru_pkg::INF_COST_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [dvru_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [dvru_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [dvru_pkg::ID_W-1:0]         i_source_node,
    input  wire logic [dvru_pkg::VEC_W-1:0]        i_vec_cost_0,
    input  wire logic [dvru_pkg::VEC_W-1:0]        i_vec_cost_1,
    input  wire logic [dvru_pkg::VEC_W-1:0]        i_vec_cost_2,
    input  wire logic [dvru_pkg::VEC_W-1:0]        i_vec_cost_3,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [dvru_pkg::ID_W-1:0]         o_dest_node,
    output logic      [dvru_pkg::COST_W-1:0]       o_own_cost_0,
    output logic      [dvru_pkg::COST_W-1:0]       o_own_cost_1,
    output logic      [dvru_pkg::COST_W-1:0]       o_own_cost_2,
    output logic      [dvru_pkg::COST_W-1:0]       o_own_cost_3,
    output logic                                   o_last_packet
);
    import dvru_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int RW = NODES * COST_W;
    localparam logic [COST_W-1:0] INF_C = COST_W'(INFINITE_COST);

    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_node_id;
    logic [CFG_W-1:0]   r_link;
    logic [ID_W-1:0]    r_src;
    logic               r_ok;
    logic [RW-1:0]      r_vec;
    logic [RW-1:0]      r_own;
    logic [NODES-1:0]   r_mask;
    logic [ID_W-1:0]    r_dest;
    logic               r_last;

    logic [VEC_W-1:0]   w_vec_in [COST_PORTS];
    logic [RW-1:0]      w_vec_clamped;
    logic [RW-1:0]      w_init_row;
    logic [NODES-1:0]   w_dest_mask;
    logic [IW-1:0]      w_me;
    logic [IW-1:0]      w_src_ix;
    logic [IW-1:0]      w_rd_addr;
    logic [IW-1:0]      w_wr_addr;
    logic [RW-1:0]      w_wr_data;
    logic               w_wr_en;
    logic [RW-1:0]      w_rd_data;
    logic [RW-1:0]      w_new_row;
    logic               w_improved;
    logic               w_load_out;
    logic               w_send;
    logic [NODES-1:0]   w_rest;
    logic [NODES-1:0]   w_pick;
    logic [ID_W-1:0]    w_low;
    logic [LINK_W-1:0]  w_lk;

    assign w_vec_in[0] = i_vec_cost_0;
    assign w_vec_in[1] = i_vec_cost_1;
    assign w_vec_in[2] = i_vec_cost_2;
    assign w_vec_in[3] = i_vec_cost_3;

    assign w_me     = r_node_id[IW-1:0];
    assign w_src_ix = r_src[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
            r_link    <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_NODE_ID:    r_node_id <= i_cfg_wdata[ID_W-1:0];
                CFG_LINK_COSTS: r_link    <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        w_lk = '0;
        for (int k = 0; k < NODES; k++) begin
            w_lk = r_link[k*LINK_W +: LINK_W];
            w_init_row[k*COST_W +: COST_W] = (w_lk > LINK_W'(INFINITE_COST)) ? INF_C
                                                                             : w_lk[COST_W-1:0];
            w_dest_mask[k] = (w_lk < LINK_W'(INFINITE_COST)) && (ID_W'(k) != r_node_id);
            w_vec_clamped[k*COST_W +: COST_W] = (w_vec_in[k] > VEC_W'(INFINITE_COST))
                                                ? INF_C : COST_W'(w_vec_in[k]);
        end
    end

    dvru_table #(
        .NODES         (NODES),
        .INFINITE_COST (INFINITE_COST)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_wr_en),
        .i_me       (w_me),
        .i_init_row (w_init_row),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data)
    );

    dvru_relax #(
        .NODES (NODES)
    ) u_relax (
        .i_own_row  (w_rd_data),
        .i_vec_row  (r_vec),
        .i_src      (w_src_ix),
        .o_new_row  (w_new_row),
        .o_improved (w_improved)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        w_rd_addr  = w_src_ix;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_src_ix;
        w_wr_data  = r_vec;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_RD_SRC;
                end
            end
            S_RD_SRC: begin
                n_state = r_ok ? S_RD_OWN : S_IDLE;
            end
            S_RD_OWN: begin
                w_rd_addr = w_me;
                n_state   = S_IDLE;
                if (w_rd_data != r_vec) begin
                    w_wr_en = 1'b1;
                    if (r_src != r_node_id) begin
                        n_state = S_RELAX;
                    end
                end
            end
            S_RELAX: begin
                w_wr_addr = w_me;
                w_wr_data = w_new_row;
                n_state   = S_IDLE;
                if (w_improved) begin
                    w_wr_en = 1'b1;
                    if (|w_dest_mask) begin
                        w_load_out = 1'b1;
                        n_state    = S_SEND;
                    end
                end
            end
            S_SEND: begin
                if (i_ready && r_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_src <= i_source_node;
            r_vec <= w_vec_clamped;
            r_ok  <= (int'(i_source_node) < NODES) && (int'(r_node_id) < NODES);
        end
    end

    assign w_send = o_valid && i_ready;
    assign w_rest = r_mask & ~(NODES'(1) << r_dest);
    assign w_pick = w_load_out ? w_dest_mask : w_rest;

    always_comb begin
        w_low = '0;
        for (int k = NODES - 1; k >= 0; k--) begin
            if (w_pick[k]) begin
                w_low = ID_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_own <= w_new_row;
        end
        if (w_load_out || w_send) begin
            r_mask <= w_pick;
            r_dest <= w_low;
            r_last <= (w_pick & (w_pick - NODES'(1))) == '0;
        end
    end

    assign o_valid       = (r_state == S_SEND);
    assign o_dest_node   = r_dest;
    assign o_last_packet = r_last;

    logic [COST_W-1:0] w_own_out [COST_PORTS];

    for (genvar k = 0; k < COST_PORTS; k++) begin : g_own
        if (k < NODES) begin : g_used
            assign w_own_out[k] = r_own[k*COST_W +: COST_W];
        end else begin : g_unused
            assign w_own_out[k] = INF_C;
        end
    end

    assign o_own_cost_0 = w_own_out[0];
    assign o_own_cost_1 = w_own_out[1];
    assign o_own_cost_2 = w_own_out[2];
    assign o_own_cost_3 = w_own_out[3];

    a_send_has_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_mask[r_dest[IW-1:0]])
        else $error("update packet offered for a node outside the destination set");

    a_more_after_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_packet) |=> o_valid)
        else $error("packet sequence ended without a last packet");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_RD_SRC))
        else $error("accepted request did not start a table read");

    a_relax_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX) |-> (r_ok && (r_src != r_node_id)))
        else $error("relaxation entered for an ignored or self request");

endmodule
`default_nettype wire

### rtl/core/dvru_table.sv
`default_nettype none
// ============================================================================
// dvru_table: distance table memory
// One row per node, registered read. Rows not yet written read as
// their initial value: the link cost row for this node, infinite otherwise.
// ============================================================================
module dvru_table #(
    parameter int NODES         = dvru_pkg::NODES_DEF,
    parameter int INFINITE_COST = dvru_pkg::INF_COST_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_clear,
    input  wire logic [$clog2(NODES)-1:0]              i_me,
    input  wire logic [NODES*dvru_pkg::COST_W-1:0]     i_init_row,
    input  wire logic [$clog2(NODES)-1:0]              i_rd_addr,
    output logic      [NODES*dvru_pkg::COST_W-1:0]     o_rd_data,
    input  wire logic                                  i_wr_en,
    input  wire logic [$clog2(NODES)-1:0]              i_wr_addr,
    input  wire logic [NODES*dvru_pkg::COST_W-1:0]     i_wr_data
);
    import dvru_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int RW = NODES * COST_W;
    localparam logic [COST_W-1:0] INF_C = COST_W'(INFINITE_COST);

    logic [RW-1:0]    r_mem [NODES];
    logic [NODES-1:0] r_valid;
    logic [RW-1:0]    r_rd_data;
    logic             r_rd_valid;
    logic [IW-1:0]    r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_comb begin
        if (r_rd_valid) begin
            o_rd_data = r_rd_data;
        end else if (r_rd_addr == i_me) begin
            o_rd_data = i_init_row;
        end else begin
            o_rd_data = {NODES{INF_C}};
        end
    end

endmodule
`default_nettype wire

### rtl/core/dvru_relax.sv
`default_nettype none
// ============================================================================
// dvru_relax: Bellman-Ford relaxation lanes
// One lane per destination: own[i] = min(own[i], own[src] + vec[i]).
// ============================================================================
module dvru_relax #(
    parameter int NODES = dvru_pkg::NODES_DEF
) (
    input  wire logic [NODES*dvru_pkg::COST_W-1:0] i_own_row,
    input  wire logic [NODES*dvru_pkg::COST_W-1:0] i_vec_row,
    input  wire logic [$clog2(NODES)-1:0]          i_src,
    output logic      [NODES*dvru_pkg::COST_W-1:0] o_new_row,
    output logic                                   o_improved
);
    import dvru_pkg::*;

    logic [COST_W-1:0] w_own_src;
    logic [SUM_W-1:0]  w_via  [NODES];
    logic [NODES-1:0]  w_better;

    assign w_own_src = i_own_row[i_src*COST_W +: COST_W];

    always_comb begin
        for (int k = 0; k < NODES; k++) begin
            w_via[k] = SUM_W'(w_own_src) + SUM_W'(i_vec_row[k*COST_W +: COST_W]);
            w_better[k] = SUM_W'(i_own_row[k*COST_W +: COST_W]) > w_via[k];
            o_new_row[k*COST_W +: COST_W] = w_better[k] ? w_via[k][COST_W-1:0]
                                                        : i_own_row[k*COST_W +: COST_W];
        end
        o_improved = |w_better;
    end

endmodule
`default_nettype wire
